FILE: rtl/quaternion_vector_rotation_macros.svh
// ----------------------------------------------------------------------------
// quaternion vector rotation assertion macros
// shared concurrent assertion forms for the rotation block
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_MACROS_SVH

// implication checked in the same cycle, switched off while in reset
`define QVR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after, also active across reset
`define QVR_ASSERT_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// shared types and constants of the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qvr_pkg;

  // quaternion components are 16 bit signed
  localparam int Q_W = 16;
  // product of two quaternion components
  localparam int QPROD_W = 2 * Q_W;
  // narrowest matrix entry: twice a sum of two products
  localparam int MAT_MIN_W = QPROD_W + 2;

  typedef logic signed [Q_W-1:0]     quat_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;

  typedef enum logic {
    OP_BODY_TO_EARTH = 1'b0,
    OP_EARTH_TO_BODY = 1'b1
  } rot_op_t;

  // pairwise quaternion products needed by the rotation matrix
  typedef struct packed {
    qprod_t xx;
    qprod_t yy;
    qprod_t zz;
    qprod_t xy;
    qprod_t xz;
    qprod_t yz;
    qprod_t wx;
    qprod_t wy;
    qprod_t wz;
  } qprods_t;

endpackage

FILE: rtl/qvr_in_if.sv
// ----------------------------------------------------------------------------
// qvr_in_if
// request channel: operation, attitude quaternion and vector
// ----------------------------------------------------------------------------
interface qvr_in_if
  import qvr_pkg::*;
#(
  parameter int VEC_WIDTH = 32
);

  logic                        valid;
  logic                        ready;
  rot_op_t                     operation;
  quat_t                       q_w;
  quat_t                       q_x;
  quat_t                       q_y;
  quat_t                       q_z;
  logic signed [VEC_WIDTH-1:0] in_x;
  logic signed [VEC_WIDTH-1:0] in_y;
  logic signed [VEC_WIDTH-1:0] in_z;

  modport source (
    output valid, operation, q_w, q_x, q_y, q_z, in_x, in_y, in_z,
    input  ready
  );

  modport sink (
    input  valid, operation, q_w, q_x, q_y, q_z, in_x, in_y, in_z,
    output ready
  );

endinterface

FILE: rtl/qvr_out_if.sv
// ----------------------------------------------------------------------------
// qvr_out_if
// result channel: rotated vector and saturation flag
// ----------------------------------------------------------------------------
interface qvr_out_if #(
  parameter int VEC_WIDTH = 32
);

  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] out_x;
  logic signed [VEC_WIDTH-1:0] out_y;
  logic signed [VEC_WIDTH-1:0] out_z;
  logic                        clamped;

  modport source (
    output valid, out_x, out_y, out_z, clamped,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, clamped,
    output ready
  );

endinterface

FILE: rtl/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix
// two stages: quaternion products, then matrix entries with optional transpose
// ----------------------------------------------------------------------------
module qvr_matrix
  import qvr_pkg::*;
#(
  parameter int QFB = 14,
  parameter int VW  = 32,
  parameter int MW  = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rot_op_t              op,
  input  quat_t                q_w,
  input  quat_t                q_x,
  input  quat_t                q_y,
  input  quat_t                q_z,
  input  logic signed [VW-1:0] vec [3],
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [MW-1:0] mat [3][3],
  output logic signed [VW-1:0] vec_q [3]
);

  localparam logic signed [MW-1:0] ONE = MW'(1) << (2 * QFB);

  // stage one
  logic                 vld1;
  rot_op_t              op1;
  qprods_t              prod1;
  logic signed [VW-1:0] vec1 [3];
  // stage two
  logic                 vld2;
  logic                 en1;
  logic                 en2;
  logic signed [MW-1:0] rm [3][3];

  assign en2      = !vld2 || dn_ready;
  assign en1      = !vld1 || en2;
  assign up_ready = en1;
  assign dn_valid = vld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (en1) vld1 <= up_valid;
      if (en2) vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1      <= op;
      prod1.xx <= q_x * q_x;
      prod1.yy <= q_y * q_y;
      prod1.zz <= q_z * q_z;
      prod1.xy <= q_x * q_y;
      prod1.xz <= q_x * q_z;
      prod1.yz <= q_y * q_z;
      prod1.wx <= q_w * q_x;
      prod1.wy <= q_w * q_y;
      prod1.wz <= q_w * q_z;
      vec1     <= vec;
    end
  end

  // rotation matrix, body to earth orientation
  always_comb begin
    rm[0][0] = ONE - ((MW'(prod1.yy) + MW'(prod1.zz)) <<< 1);
    rm[0][1] = (MW'(prod1.xy) - MW'(prod1.wz)) <<< 1;
    rm[0][2] = (MW'(prod1.xz) + MW'(prod1.wy)) <<< 1;
    rm[1][0] = (MW'(prod1.xy) + MW'(prod1.wz)) <<< 1;
    rm[1][1] = ONE - ((MW'(prod1.xx) + MW'(prod1.zz)) <<< 1);
    rm[1][2] = (MW'(prod1.yz) - MW'(prod1.wx)) <<< 1;
    rm[2][0] = (MW'(prod1.xz) - MW'(prod1.wy)) <<< 1;
    rm[2][1] = (MW'(prod1.yz) + MW'(prod1.wx)) <<< 1;
    rm[2][2] = ONE - ((MW'(prod1.xx) + MW'(prod1.yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      vec_q <= vec1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          unique case (op1)
            OP_BODY_TO_EARTH: mat[i][j] <= rm[i][j];
            OP_EARTH_TO_BODY: mat[i][j] <= rm[j][i];
            default:          mat[i][j] <= rm[i][j];
          endcase
        end
      end
    end
  end

endmodule

FILE: rtl/qvr_dot.sv
// ----------------------------------------------------------------------------
// qvr_dot
// three stages: split partial products, full products, rounded row sums
// ----------------------------------------------------------------------------
module qvr_dot #(
  parameter int QFB = 14,
  parameter int VW  = 32,
  parameter int MW  = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [MW-1:0]    mat [3][3],
  input  logic signed [VW-1:0]    vec [3],
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [MW+VW+1:0] acc [3]
);

  localparam int VL    = VW / 2;
  localparam int VH    = VW - VL;
  localparam int PL_W  = MW + VL + 1;
  localparam int PH_W  = MW + VH;
  localparam int P_W   = MW + VW;
  localparam int ACC_W = P_W + 2;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (2 * QFB - 1);

  logic [2:0]             vld;
  logic [2:0]             en;
  logic signed [PL_W-1:0] pp_lo [3][3];
  logic signed [PH_W-1:0] pp_hi [3][3];
  logic signed [P_W-1:0]  prod  [3][3];

  assign en[2]    = !vld[2] || dn_ready;
  assign en[1]    = !vld[1] || en[2];
  assign en[0]    = !vld[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= up_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // vector split in an unsigned low half and a signed high half
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_lo[i][j] <= mat[i][j] * $signed({1'b0, vec[j][VL-1:0]});
          pp_hi[i][j] <= mat[i][j] * $signed(vec[j][VW-1:VL]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= (P_W'(pp_hi[i][j]) <<< VL) + P_W'(pp_lo[i][j]);
        end
      end
    end
  end

  // row sum with the half lsb rounding constant folded in
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2]) + RND;
      end
    end
  end

endmodule

FILE: rtl/qvr_sat.sv
// ----------------------------------------------------------------------------
// qvr_sat
// scale back to vector format, saturate, and hold the result transaction
// ----------------------------------------------------------------------------
module qvr_sat #(
  parameter int QFB = 14,
  parameter int VW  = 32,
  parameter int MW  = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [MW+VW+1:0] acc [3],
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [VW-1:0]    res [3],
  output logic                    clamped
);

  localparam int ACC_W = MW + VW + 2;
  localparam int SH_W  = ACC_W - 2 * QFB;
  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

  logic                 vld;
  logic                 en;
  logic signed [VW-1:0] sat [3];
  logic [2:0]           hit;

  assign en       = !vld || dn_ready;
  assign up_ready = en;
  assign dn_valid = vld;

  always_comb begin
    logic [SH_W-1:0]  sh;
    logic [SH_W-VW:0] top;
    for (int i = 0; i < 3; i++) begin
      sh  = acc[i][ACC_W-1:2*QFB];
      top = sh[SH_W-1:VW-1];
      // fits when every bit above the result sign matches it
      if ((&top) || !(|top)) begin
        sat[i] = $signed(sh[VW-1:0]);
        hit[i] = 1'b0;
      end else begin
        sat[i] = sh[SH_W-1] ? V_MIN : V_MAX;
        hit[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res     <= sat;
      clamped <= |hit;
    end
  end

endmodule

FILE: rtl/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// rotates a vector by a unit attitude quaternion, body to earth or back
// ----------------------------------------------------------------------------
//
//   channel   modport             payload
//   -------   -----------------   -------------------------------------------
//   request   qvr_in_if.sink      operation, q_w, q_x, q_y, q_z, in_x, in_y, in_z
//   result    qvr_out_if.source   out_x, out_y, out_z, clamped
//
//   one transaction per cycle sustained while result.ready stays high
//   six register stages from request to result: products, matrix, partial
//   products, full products, row sums, saturation and output register
//   reset (synchronous, active high) clears only the valid bits of the stages
//   each stage loads when it is empty or the stage after it moves, so a
//   stalled result holds only the stages behind it and bubbles close up
//
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_macros.svh"

module quaternion_vector_rotation
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_WIDTH      = 32
) (
  input  logic             clk,
  input  logic             rst,
  qvr_in_if.sink           request,
  qvr_out_if.source        result
);

  // matrix entries in q.(2*frac), wide enough for one and for 2*(a*b+c*d)
  localparam int MW = (2 * QUAT_FRAC_BITS + 2 > MAT_MIN_W) ?
                      2 * QUAT_FRAC_BITS + 2 : MAT_MIN_W;
  localparam int ACC_W = MW + VEC_WIDTH + 2;
  localparam logic signed [VEC_WIDTH-1:0] V_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] V_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  // vector as entered
  logic signed [VEC_WIDTH-1:0] vec_in  [3];
  // matrix stage to dot product stage
  logic                        mat_valid;
  logic                        mat_ready;
  logic signed [MW-1:0]        mat     [3][3];
  logic signed [VEC_WIDTH-1:0] vec_mat [3];
  // dot product stage to saturation stage
  logic                        acc_valid;
  logic                        acc_ready;
  logic signed [ACC_W-1:0]     acc     [3];
  // rotated vector
  logic signed [VEC_WIDTH-1:0] res     [3];
  // result held back, flagged result, and any component pinned at a limit
  logic                        out_stall;
  logic                        clamp_seen;
  logic                        at_limit;

  assign vec_in[0] = request.in_x;
  assign vec_in[1] = request.in_y;
  assign vec_in[2] = request.in_z;

  // quaternion products and the matrix, transposed for earth to body
  qvr_matrix #(
    .QFB (QUAT_FRAC_BITS),
    .VW  (VEC_WIDTH),
    .MW  (MW)
  ) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (request.valid),
    .up_ready (request.ready),
    .op       (request.operation),
    .q_w      (request.q_w),
    .q_x      (request.q_x),
    .q_y      (request.q_y),
    .q_z      (request.q_z),
    .vec      (vec_in),
    .dn_valid (mat_valid),
    .dn_ready (mat_ready),
    .mat      (mat),
    .vec_q    (vec_mat)
  );

  // exact row by vector dot products plus rounding constant
  qvr_dot #(
    .QFB (QUAT_FRAC_BITS),
    .VW  (VEC_WIDTH),
    .MW  (MW)
  ) u_dot (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mat_valid),
    .up_ready (mat_ready),
    .mat      (mat),
    .vec      (vec_mat),
    .dn_valid (acc_valid),
    .dn_ready (acc_ready),
    .acc      (acc)
  );

  // shift back to the vector format, dropping 2*QUAT_FRAC_BITS fractional bits, clamp, output register
  qvr_sat #(
    .QFB (QUAT_FRAC_BITS),
    .VW  (VEC_WIDTH),
    .MW  (MW)
  ) u_sat (
    .clk      (clk),
    .rst      (rst),
    .up_valid (acc_valid),
    .up_ready (acc_ready),
    .acc      (acc),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .res      (res),
    .clamped  (result.clamped)
  );

  assign result.out_x = res[0];
  assign result.out_y = res[1];
  assign result.out_z = res[2];

  assign out_stall  = result.valid && !result.ready;
  assign clamp_seen = result.valid && result.clamped;
  assign at_limit   = (result.out_x == V_MAX) || (result.out_x == V_MIN) ||
                      (result.out_y == V_MAX) || (result.out_y == V_MIN) ||
                      (result.out_z == V_MAX) || (result.out_z == V_MIN);

  // a stalled request can only come from a full pipe behind a waiting result
  `QVR_ASSERT_IMP(a_in_stall, clk, rst, !request.ready, out_stall, "input stall, no output stall")

  // the flag implies at least one component sits at a range limit
  `QVR_ASSERT_IMP(a_clamp_at_limit, clk, rst, clamp_seen, at_limit, "clamped with no limit value")

  // reset empties every stage
  `QVR_ASSERT_NXT(a_reset_empties, clk, rst, !result.valid, "result valid straight after reset")

endmodule
